// ===== sv/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// prop must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// ante at one edge implies cons at the same edge
`define ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// ante at one edge implies cons at the next edge
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/ifrl_pkg.sv =====
package ifrl_pkg;

  localparam int unsigned ROUTE_ENTRIES = 16;
  localparam int unsigned CNT_W = $clog2(ROUTE_ENTRIES + 1);
  localparam int unsigned HEADER_WORDS = 10;
  localparam int unsigned WIDX_W = 4;
  localparam int unsigned SUM_W = 20;

  localparam logic [WIDX_W-1:0] WORD_TTL = WIDX_W'(4);
  localparam logic [WIDX_W-1:0] WORD_CSUM = WIDX_W'(5);
  localparam logic [WIDX_W-1:0] WORD_DST_HI = WIDX_W'(8);
  localparam logic [WIDX_W-1:0] WORD_LAST = WIDX_W'(HEADER_WORDS - 1);

  localparam logic [15:0] TTL_ONE = 16'h0100;

  typedef enum logic [1:0] {
    FUNC_CLEAR = 2'd0,
    FUNC_ADD   = 2'd1,
    FUNC_WORD  = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    ACT_FORWARD     = 2'd0,
    ACT_LOCAL       = 2'd1,
    ACT_DISCARD_TTL = 2'd2,
    ACT_NO_ROUTE    = 2'd3
  } action_e;

  typedef struct packed {
    logic [31:0] dest;
    logic [5:0]  len;
    logic [31:0] hop;
  } route_t;

  typedef struct packed {
    logic        vld;
    logic        hit;
    logic [31:0] hop;
  } tok_t;

  function automatic logic [31:0] prefix_mask(input logic [5:0] len);
    logic [31:0] m;
    if (len == 6'd0) begin
      m = 32'h0;
    end else if (len >= 6'd32) begin
      m = 32'hFFFF_FFFF;
    end else begin
      m = ~(32'hFFFF_FFFF >> len);
    end
    return m;
  endfunction

endpackage

// ===== sv/ifrl_cell.sv =====
module ifrl_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_en_i,
  input  ifrl_pkg::route_t wr_route_i,
  input  logic           entry_vld_i,
  input  logic [31:0]    dst_i,
  input  ifrl_pkg::tok_t tok_i,
  output ifrl_pkg::tok_t tok_o
);
  import ifrl_pkg::*;
  `include "assert_macros.svh"

  route_t entry_q;
  tok_t   tok_q, tok_d;
  logic   match;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      entry_q <= wr_route_i;
    end
  end

  assign match = entry_vld_i && ((prefix_mask(entry_q.len) & dst_i) == entry_q.dest);

  always_comb begin
    tok_d     = tok_i;
    tok_d.hit = tok_i.hit | (tok_i.vld & match);
    if (tok_i.vld && !tok_i.hit && match) begin
      tok_d.hop = entry_q.hop;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

  `ASSERT_IMPLY(a_hit_has_vld, tok_q.hit, tok_q.vld, "hit flag on an empty slot")
  `ASSERT_NEXT(a_hit_kept, tok_i.vld && tok_i.hit, tok_q.hit, "earlier hit lost")
  `ASSERT_IMPLY(a_no_write_busy, tok_i.vld, !wr_en_i, "route written during lookup")

endmodule

// ===== sv/ipv4_forward_route_lookup.sv =====
// IPv4 forwarding route lookup.
// Command channel: an item transfers at a rising edge with start high and busy
// low. func_i selects clear table, add route or one 16-bit header word; route
// fields matter for add, header_word_i for a header word. Ten header words in
// network order make one header.
// Config: local_addr_we_i writes local_addr_i into the local address register.
// Result: after the tenth word one result is driven for exactly one cycle with
// result_valid_o high. The receiver cannot stall; results are never held.
// Latency: for a zero TTL or a local destination the strobe comes in the cycle
// after the tenth word. Otherwise the lookup token walks the row of route
// cells, one cell per cycle, and busy stays high until the token leaves the
// last cell, when the result register gives the strobe. The cell chain length
// sets the lookup time. Adds and clears give no result.
// Reset: the route count, the word index and the local address clear; route
// contents stay unknown until written.
module ipv4_forward_route_lookup (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  func_i,
  input  logic [15:0] header_word_i,
  input  logic [31:0] route_dest_i,
  input  logic [5:0]  route_prefix_len_i,
  input  logic [31:0] route_next_hop_i,
  input  logic        local_addr_we_i,
  input  logic [31:0] local_addr_i,
  output logic        result_valid_o,
  output logic [1:0]  action_o,
  output logic [31:0] next_hop_o,
  output logic [15:0] ttl_protocol_word_o,
  output logic [15:0] header_checksum_o
);
  import ifrl_pkg::*;
  `include "assert_macros.svh"

  logic [31:0]       local_addr_q;
  logic [CNT_W-1:0]  route_cnt_q, route_cnt_d;
  logic [WIDX_W-1:0] widx_q, widx_d;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [15:0]       ttl_q, ttl_d;
  logic [15:0]       csum_q, csum_d;
  logic [31:0]       dst_q, dst_d;
  logic              busy_q, busy_d;
  logic              launch_q, launch_d;

  logic              res_vld_q, res_vld_d;
  action_e           res_act_q, res_act_d;
  logic [31:0]       res_hop_q, res_hop_d;
  logic [15:0]       res_ttl_q, res_ttl_d;
  logic [15:0]       res_csum_q, res_csum_d;

  logic              accept;
  logic              add_ok;
  logic              last_word;
  route_t            wr_route;
  tok_t              tok [ROUTE_ENTRIES+1];
  logic [ROUTE_ENTRIES:0] tok_vld;
  logic [ROUTE_ENTRIES-1:0] cell_we;
  logic [ROUTE_ENTRIES-1:0] entry_vld;

  logic [SUM_W-1:0]  s0;
  logic [16:0]       f1;
  logic [15:0]       f2;

  assign accept    = start && !busy_q;
  assign add_ok    = accept && (func_e'(func_i) == FUNC_ADD) &&
                     (route_cnt_q < CNT_W'(ROUTE_ENTRIES));
  assign last_word = accept && (func_e'(func_i) == FUNC_WORD) && (widx_q == WORD_LAST);

  assign wr_route.dest = route_dest_i;
  assign wr_route.len  = route_prefix_len_i;
  assign wr_route.hop  = route_next_hop_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      local_addr_q <= '0;
    end else if (local_addr_we_i) begin
      local_addr_q <= local_addr_i;
    end
  end

  // Header word capture and table count
  always_comb begin
    route_cnt_d = route_cnt_q;
    widx_d      = widx_q;
    sum_d       = sum_q;
    ttl_d       = ttl_q;
    csum_d      = csum_q;
    dst_d       = dst_q;
    if (accept) begin
      case (func_e'(func_i))
        FUNC_CLEAR: begin
          route_cnt_d = '0;
        end
        FUNC_ADD: begin
          if (add_ok) begin
            route_cnt_d = route_cnt_q + CNT_W'(1);
          end
        end
        FUNC_WORD: begin
          sum_d = (widx_q == '0) ? '0 : sum_q;
          if (widx_q == WORD_TTL) begin
            ttl_d = header_word_i;
          end
          if (widx_q == WORD_CSUM) begin
            csum_d = header_word_i;
          end else begin
            sum_d = sum_d + SUM_W'(header_word_i);
          end
          if (widx_q == WORD_DST_HI) begin
            dst_d = {header_word_i, dst_q[15:0]};
          end
          if (widx_q == WORD_LAST) begin
            dst_d  = {dst_q[31:16], header_word_i};
            widx_d = '0;
          end else begin
            widx_d = widx_q + WIDX_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Forward checksum: drop one from TTL, fold twice, complement
  assign s0 = sum_q - SUM_W'(TTL_ONE);
  assign f1 = 17'(s0[15:0]) + 17'(s0[SUM_W-1:16]);
  assign f2 = f1[15:0] + 16'(f1[16]);

  // Decision and result
  always_comb begin
    busy_d     = busy_q;
    launch_d   = 1'b0;
    res_vld_d  = 1'b0;
    res_act_d  = res_act_q;
    res_hop_d  = res_hop_q;
    res_ttl_d  = res_ttl_q;
    res_csum_d = res_csum_q;
    if (last_word) begin
      res_hop_d  = '0;
      res_ttl_d  = ttl_d;
      res_csum_d = csum_d;
      if (ttl_d[15:8] == 8'd0) begin
        res_vld_d = 1'b1;
        res_act_d = ACT_DISCARD_TTL;
      end else if (dst_d == local_addr_q) begin
        res_vld_d = 1'b1;
        res_act_d = ACT_LOCAL;
      end else begin
        launch_d = 1'b1;
        busy_d   = 1'b1;
      end
    end
    if (tok[ROUTE_ENTRIES].vld) begin
      busy_d    = 1'b0;
      res_vld_d = 1'b1;
      if (tok[ROUTE_ENTRIES].hit) begin
        res_act_d  = ACT_FORWARD;
        res_hop_d  = tok[ROUTE_ENTRIES].hop;
        res_ttl_d  = ttl_q - TTL_ONE;
        res_csum_d = ~f2;
      end else begin
        res_act_d  = ACT_NO_ROUTE;
        res_hop_d  = '0;
        res_ttl_d  = ttl_q;
        res_csum_d = csum_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      route_cnt_q <= '0;
      widx_q      <= '0;
      sum_q       <= '0;
      ttl_q       <= '0;
      csum_q      <= '0;
      dst_q       <= '0;
      busy_q      <= 1'b0;
      launch_q    <= 1'b0;
      res_vld_q   <= 1'b0;
      res_act_q   <= ACT_FORWARD;
    end else begin
      route_cnt_q <= route_cnt_d;
      widx_q      <= widx_d;
      sum_q       <= sum_d;
      ttl_q       <= ttl_d;
      csum_q      <= csum_d;
      dst_q       <= dst_d;
      busy_q      <= busy_d;
      launch_q    <= launch_d;
      res_vld_q   <= res_vld_d;
      res_act_q   <= res_act_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_hop_q  <= res_hop_d;
    res_ttl_q  <= res_ttl_d;
    res_csum_q <= res_csum_d;
  end

  // Route cell row; the lookup token advances one cell per cycle
  assign tok[0].vld = launch_q;
  assign tok[0].hit = 1'b0;
  assign tok[0].hop = '0;

  for (genvar i = 0; i < ROUTE_ENTRIES; i++) begin : g_cell
    assign cell_we[i]   = add_ok && (route_cnt_q == CNT_W'(i));
    assign entry_vld[i] = route_cnt_q > CNT_W'(i);

    ifrl_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .wr_en_i     (cell_we[i]),
      .wr_route_i  (wr_route),
      .entry_vld_i (entry_vld[i]),
      .dst_i       (dst_q),
      .tok_i       (tok[i]),
      .tok_o       (tok[i+1])
    );
  end

  for (genvar j = 0; j <= ROUTE_ENTRIES; j++) begin : g_vld
    assign tok_vld[j] = tok[j].vld;
  end

  assign busy                = busy_q;
  assign result_valid_o      = res_vld_q;
  assign action_o            = res_act_q;
  assign next_hop_o          = res_hop_q;
  assign ttl_protocol_word_o = res_ttl_q;
  assign header_checksum_o   = res_csum_q;

  `ASSERT_ALWAYS(a_one_token, $onehot0(tok_vld), "more than one lookup in flight")
  `ASSERT_IMPLY(a_token_busy, |tok_vld, busy_q, "lookup running while not busy")
  `ASSERT_IMPLY(a_busy_idx, busy_q, widx_q == '0, "lookup started mid header")
  `ASSERT_ALWAYS(a_cnt_range, route_cnt_q <= CNT_W'(ROUTE_ENTRIES), "route count overflow")

endmodule
